[rtl/core/blqd_pkg.sv]
// Package for the bounded list deque core.
// Holds request and status codes, field widths and the cell control struct.
// No dependencies.
package blqd_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int DATA_W       = 32;
   localparam int TYPE_W       = 3;
   localparam int POS_W        = 7;
   localparam int STATUS_W     = 2;
   localparam int COUNT_W      = 7;
   localparam int REQ_TDATA_W  = 40;
   localparam int RSP_TDATA_W  = 48;

   typedef enum logic [TYPE_W-1:0] {
      REQ_PUSH_BACK  = 3'd0,
      REQ_PUSH_FRONT = 3'd1,
      REQ_POP_BACK   = 3'd2,
      REQ_POP_FRONT  = 3'd3,
      REQ_INSERT     = 3'd4
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic put;
      logic shift_down;
      logic drop_back;
   } cell_ctrl_type;

endpackage

[rtl/core/bounded_list_deque_core.sv]
// Bounded deque with positional insert: one request in, one response out.
// Response valid is registered: it rises in the cycle after the request transaction.
// Throughput: 1 request per cycle while the response is not held off; every cell of the chain shifts in the same cycle.
// Reset: synchronous, clears the count, occupied flags and response valid; no clearing pass.
// Depends on blqd_pkg and blqd_cell.
module bounded_list_deque_core #(
   parameter int CAPACITY = blqd_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] value, [38:32] position, [39] zero
   input  logic [blqd_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [2:0] req_type
   input  logic [blqd_pkg::TYPE_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] pop_value, [33:32] status, [40:34] count, [47:41] zero
   output logic [blqd_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import blqd_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
   localparam int PAD_W = RSP_TDATA_W - DATA_W - STATUS_W - COUNT_W;

   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]      rsp_value_ff, rsp_value_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                   accept;
   cell_ctrl_type          ctrl;
   logic [CNT_W-1:0]       ins_idx;
   logic [CMP_W-1:0]       pos_ext, cnt_ext;
   logic [DATA_W-1:0]      req_value;
   logic [POS_W-1:0]       req_position;
   req_kind_type           req_kind;
   logic                   is_full, is_empty;
   logic [DATA_W-1:0]      back_value;

   logic [CAPACITY-1:0]    occ;
   logic [CAPACITY-1:0]    last;
   logic [DATA_W-1:0]      cell_value [CAPACITY];

   assign req_value    = req_tdata[DATA_W-1:0];
   assign req_position = req_tdata[DATA_W+POS_W-1:DATA_W];
   assign req_kind     = req_kind_type'(req_tuser);
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;
   assign is_full      = (count_ff == CNT_FULL);
   assign is_empty     = (count_ff == '0);
   assign pos_ext      = CMP_W'(req_position);
   assign cnt_ext      = CMP_W'(count_ff);

   always_comb begin
      back_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         back_value = back_value | ({DATA_W{last[i]}} & cell_value[i]);
      end
   end

   always_comb begin
      ctrl          = '0;
      ins_idx       = count_ff;
      count_in      = count_ff;
      rsp_value_in  = '0;
      rsp_status_in = ST_OK;
      case (req_kind)
         REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT: begin
            if (req_kind == REQ_PUSH_FRONT) begin
               ins_idx = '0;
            end else if (req_kind == REQ_INSERT && pos_ext < cnt_ext) begin
               ins_idx = CNT_W'(pos_ext);
            end
            if (is_full) begin
               rsp_status_in = ST_FULL;
            end else begin
               ctrl.put = accept;
               count_in = count_ff + 1'b1;
            end
         end
         REQ_POP_BACK: begin
            if (is_empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               ctrl.drop_back = accept;
               rsp_value_in   = back_value;
               count_in       = count_ff - 1'b1;
            end
         end
         REQ_POP_FRONT: begin
            if (is_empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               ctrl.shift_down = accept;
               rsp_value_in    = cell_value[0];
               count_in        = count_ff - 1'b1;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      rsp_count_in = COUNT_W'(count_in);
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   end

   generate
      for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
         logic              l_occ, r_occ;
         logic [DATA_W-1:0] l_value, r_value;
         if (g == 0) begin : g_first
            assign l_occ   = 1'b1;
            assign l_value = req_value;
         end else begin : g_mid_l
            assign l_occ   = occ[g-1];
            assign l_value = cell_value[g-1];
         end
         if (g == CAPACITY - 1) begin : g_end
            assign r_occ   = 1'b0;
            assign r_value = '0;
         end else begin : g_mid_r
            assign r_occ   = occ[g+1];
            assign r_value = cell_value[g+1];
         end
         blqd_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .ins_idx     (ins_idx),
            .new_value   (req_value),
            .left_occ    (l_occ),
            .left_value  (l_value),
            .right_occ   (r_occ),
            .right_value (r_value),
            .occ         (occ[g]),
            .is_last     (last[g]),
            .value       (cell_value[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_count_ff, rsp_status_ff, rsp_value_ff};

`ifndef ASSERT_OFF
   a_front_occ: assert property (@(posedge clock) disable iff (reset)
      occ[0] == (count_ff != '0))
      else $error("front cell occupancy disagrees with count");

   a_back_occ: assert property (@(posedge clock) disable iff (reset)
      occ[CAPACITY-1] == (count_ff == CNT_FULL))
      else $error("back cell occupancy disagrees with full count");

   a_one_last: assert property (@(posedge clock) disable iff (reset)
      $onehot0(last) && ((last == '0) == (count_ff == '0)))
      else $error("tail marker is not unique");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && is_empty && (req_kind == REQ_POP_BACK || req_kind == REQ_POP_FRONT))
      |=> (rsp_status_ff == ST_EMPTY && count_ff == '0))
      else $error("pop on empty list changed state or missed status");
`endif

endmodule

[rtl/core/blqd_cell.sv]
// One storage cell of the deque chain: a value and an occupied flag.
// Takes data from its left or right neighbor or the broadcast value.
// Depends on blqd_pkg.
module blqd_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic                    clock,
   input  logic                    reset,
   input  blqd_pkg::cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0]        ins_idx,
   input  logic [blqd_pkg::DATA_W-1:0] new_value,
   input  logic                    left_occ,
   input  logic [blqd_pkg::DATA_W-1:0] left_value,
   input  logic                    right_occ,
   input  logic [blqd_pkg::DATA_W-1:0] right_value,
   output logic                    occ,
   output logic                    is_last,
   output logic [blqd_pkg::DATA_W-1:0] value
);
   import blqd_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

   logic [DATA_W-1:0] value_ff, value_in;
   logic              occ_ff, occ_in;
   logic              sel_new, sel_up;

   always_comb begin
      sel_new  = ctrl.put && (ins_idx == MY_IDX);
      sel_up   = ctrl.put && (ins_idx < MY_IDX) && left_occ;
      value_in = value_ff;
      if (sel_new) begin
         value_in = new_value;
      end else if (sel_up) begin
         value_in = left_value;
      end else if (ctrl.shift_down) begin
         value_in = right_value;
      end
      occ_in = occ_ff;
      if (ctrl.put) begin
         occ_in = left_occ;
      end else if (ctrl.shift_down || ctrl.drop_back) begin
         occ_in = right_occ;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign occ     = occ_ff;
   assign is_last = occ_ff && !right_occ;
   assign value   = value_ff;

endmodule

[tb/tb_bounded_list_deque_core.sv]
// Testbench for bounded_list_deque_core: directed and random requests checked against a
// deque predictor, with random idling on both stream sides and long receiver hold-offs.
// Depends on blqd_pkg and the core RTL.
module tb_bounded_list_deque_core;
   import blqd_pkg::*;

   localparam int DEPTH       = CAPACITY_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_LEN    = 180;

   typedef struct {
      logic [TYPE_W-1:0]        kind;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
   } deque_request_type;

   typedef struct {
      logic [DATA_W-1:0]  pop_value;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } deque_response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [TYPE_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   deque_request_type        request_backlog[$];
   deque_response_type       owed_responses[$];
   logic signed [DATA_W-1:0] deque_contents[$];
   deque_request_type        on_bus;

   int errors = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int gen_count = 0;

   bounded_list_deque_core dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   task automatic advance_deque(input deque_request_type r);
      deque_response_type e;
      int slot;
      e.pop_value = '0;
      e.status = ST_OK;
      case (r.kind)
         REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT: begin
            if (deque_contents.size() >= DEPTH) begin
               e.status = ST_FULL;
            end else if (r.kind == REQ_PUSH_BACK) begin
               deque_contents.insert(deque_contents.size(), r.value);
            end else if (r.kind == REQ_PUSH_FRONT) begin
               deque_contents.insert(0, r.value);
            end else begin
               slot = (r.position < deque_contents.size()) ? int'(r.position)
                                                            : deque_contents.size();
               deque_contents.insert(slot, r.value);
            end
         end
         REQ_POP_BACK: begin
            if (deque_contents.size() == 0) begin
               e.status = ST_EMPTY;
            end else begin
               e.pop_value = deque_contents[deque_contents.size() - 1];
               deque_contents.delete(deque_contents.size() - 1);
            end
         end
         REQ_POP_FRONT: begin
            if (deque_contents.size() == 0) begin
               e.status = ST_EMPTY;
            end else begin
               e.pop_value = deque_contents[0];
               deque_contents.delete(0);
            end
         end
         default: begin
         end
      endcase
      e.count = COUNT_W'(deque_contents.size());
      owed_responses.insert(owed_responses.size(), e);
   endtask

   // driver: advance only when the bus is free or the current transaction completes
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) advance_deque(on_bus);
         if (!req_tvalid || req_tready) begin
            if (request_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus = request_backlog[0];
               request_backlog.delete(0);
               req_tvalid <= 1'b1;
               req_tdata <= {1'b0, on_bus.position, on_bus.value};
               req_tuser <= on_bus.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_requests != hold_served) begin
         hold_left <= HOLD_LEN;
         hold_served <= hold_served + 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      deque_response_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_responses.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, expected none actual %h", $time, rsp_tdata);
            end else begin
               e = owed_responses[0];
               owed_responses.delete(0);
               if (rsp_tdata[31:0] !== e.pop_value) begin
                  errors++;
                  $display("%0t: pop_value expected %h actual %h", $time, e.pop_value,
                           rsp_tdata[31:0]);
               end
               if (rsp_tdata[33:32] !== e.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d", $time, e.status,
                           rsp_tdata[33:32]);
               end
               if (rsp_tdata[40:34] !== e.count) begin
                  errors++;
                  $display("%0t: count expected %0d actual %0d", $time, e.count,
                           rsp_tdata[40:34]);
               end
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic add_request(input logic [TYPE_W-1:0] kind, input logic [DATA_W-1:0] value,
                              input logic [POS_W-1:0] position);
      deque_request_type r;
      r.kind = kind;
      r.value = value;
      r.position = position;
      request_backlog.insert(request_backlog.size(), r);
      case (kind)
         REQ_PUSH_BACK, REQ_PUSH_FRONT, REQ_INSERT: begin
            if (gen_count < DEPTH) gen_count++;
         end
         REQ_POP_BACK, REQ_POP_FRONT: begin
            if (gen_count > 0) gen_count--;
         end
         default: begin
         end
      endcase
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(19))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'h00000000;
         3: return 32'hffffffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      case ($urandom_range(9))
         0, 1: return '0;
         2: return POS_W'(DEPTH);
         3: return POS_W'(gen_count);
         4: return POS_W'($urandom_range(gen_count + 3 > 64 ? 64 : gen_count + 3));
         default: return POS_W'($urandom_range(64));
      endcase
   endfunction

   function automatic logic [TYPE_W-1:0] pick_store_kind();
      case ($urandom_range(2))
         0: return REQ_PUSH_BACK;
         1: return REQ_PUSH_FRONT;
         default: return REQ_INSERT;
      endcase
   endfunction

   function automatic logic [TYPE_W-1:0] pick_remove_kind();
      return $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
   endfunction

   task automatic add_random(input int goal);
      int made;
      int extra;
      int walk_len;
      made = 0;
      while (made < goal) begin
         case ($urandom_range(2))
            0: begin
               // fill to capacity, then knock on the full store
               while (gen_count < DEPTH && made < goal) begin
                  if ($urandom_range(9) == 0) add_request(pick_remove_kind(), pick_value(), '0);
                  else add_request(pick_store_kind(), pick_value(), pick_position());
                  made++;
               end
               extra = $urandom_range(1, 3);
               repeat (extra) begin
                  add_request(pick_store_kind(), pick_value(), pick_position());
                  made++;
               end
            end
            1: begin
               // drain to empty, then pop the empty store
               while (gen_count > 0 && made < goal) begin
                  if ($urandom_range(9) == 0) begin
                     add_request(pick_store_kind(), pick_value(), pick_position());
                  end else begin
                     add_request(pick_remove_kind(), pick_value(), pick_position());
                  end
                  made++;
               end
               extra = $urandom_range(1, 2);
               repeat (extra) begin
                  add_request(pick_remove_kind(), pick_value(), pick_position());
                  made++;
               end
            end
            default: begin
               walk_len = $urandom_range(20, 60);
               repeat (walk_len) begin
                  if ($urandom_range(29) == 0) begin
                     add_request(TYPE_W'($urandom_range(5, 7)), pick_value(), pick_position());
                  end else begin
                     add_request(TYPE_W'($urandom_range(4)), pick_value(), pick_position());
                     made++;
                  end
               end
            end
         endcase
      end
   endtask

   task automatic drain_all();
      do @(negedge clock);
      while (request_backlog.size() != 0 || req_tvalid || owed_responses.size() != 0);
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input bit with_hold,
                            input int goal);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      add_random(goal);
      if (with_hold) hold_requests++;
      drain_all();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      add_request(REQ_PUSH_BACK, 32'h7fffffff, 7'd0);
      add_request(REQ_PUSH_FRONT, 32'h80000000, 7'd64);
      add_request(REQ_INSERT, 32'h00000000, 7'd0);
      add_request(REQ_INSERT, 32'hffffffff, 7'd64);
      add_request(REQ_INSERT, 32'h55555555, 7'd1);
      add_request(REQ_INSERT, 32'haaaaaaaa, 7'd63);
      add_request(REQ_POP_BACK, 32'h12345678, 7'd5);
      add_request(REQ_POP_FRONT, 32'h0, 7'd0);
      add_request(REQ_POP_FRONT, 32'h0, 7'd0);
      add_request(REQ_POP_BACK, 32'h0, 7'd0);
      add_request(REQ_POP_FRONT, 32'h0, 7'd0);
      add_request(REQ_POP_BACK, 32'h0, 7'd0);
      add_request(REQ_POP_BACK, 32'h0, 7'd0);
      add_request(REQ_POP_FRONT, 32'hffffffff, 7'd127);
      add_request(3'd5, 32'h7fffffff, 7'd64);
      add_request(3'd6, 32'h80000000, 7'd63);
      add_request(3'd7, 32'hffffffff, 7'd1);
      add_request(REQ_INSERT, 32'hdeadbeef, 7'd10);
      add_request(REQ_POP_FRONT, 32'h0, 7'd0);
      drain_all();

      run_phase(0, 0, 1'b1, 360);
      run_phase(58, 0, 1'b0, 355);
      run_phase(0, 58, 1'b1, 355);
      run_phase(28, 28, 1'b0, 355);

      repeat (5) @(posedge clock);
      if (errors == 0) begin
         $display("bounded_list_deque_core regression: pass");
      end else begin
         $display("bounded_list_deque_core regression: fail");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("bounded_list_deque_core regression: fail");
      $finish;
   end

endmodule
